### hdl/scoo_tr_pkg.sv
// ============================================================================
// scoo_tr_pkg
// Shared types and constants for the sparse COO transpose core.
// ============================================================================
package scoo_tr_pkg;

    // field widths
    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int NCOL_W  = COL_W + 1;
    localparam int ENTRY_W = ROW_W + COL_W + VAL_W;

    // largest matrix dimension handled by the column scan
    localparam int MAX_DIM = 256;

    // register port
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // register indexes (word address bits of paddr)
    localparam logic [PADDR_W-3:0] REG_NUM_COLS = 1'b0;

    localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 9'd256;

    // controller states
    typedef enum logic [1:0] {
        S_LOAD,
        S_READ,
        S_CHECK,
        S_FLUSH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // store the accepted request
        logic clear;      // end of matrix: clear count and overflow flag
        logic scan_init;  // reset column and entry counters
        logic rd_en;      // read the entry memory
        logic step;       // advance entry / column counters
        logic take;       // move the matching entry into the hold register
        logic push;       // move the hold register to the output, not last
        logic flush;      // move the hold register to the output, last
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic limit_zero;  // effective column count is zero
        logic match;       // entry read back belongs to the current column
        logic scan_done;   // current probe is the final one of the scan
        logic hold_valid;  // hold register has an entry
        logic out_free;    // output register can take a new request
    } sts_t;

endpackage

### hdl/scoo_tr_ram.sv
// ============================================================================
// scoo_tr_ram
// Generic single write, single read RAM with registered read data.
// ============================================================================
module scoo_tr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/scoo_tr_ctrl.sv
// ============================================================================
// scoo_tr_ctrl
// Controller: loads entries, then walks the column / entry scan and drains
// the transposed list through the datapath.
// ============================================================================
module scoo_tr_ctrl
    import scoo_tr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   last_entry,
    output logic   in_stall,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_entry)
                    begin
                        if (sts.limit_zero)
                        begin
                            cmd.clear = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // a match with a full hold register waits for the output
                if (!(sts.match && sts.hold_valid && !sts.out_free))
                begin
                    cmd.take = sts.match;
                    cmd.push = sts.match && sts.hold_valid;
                    cmd.step = 1'b1;
                    state_next = sts.scan_done ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH:
            begin
                if (!sts.hold_valid)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_LOAD;
                end
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // read data is only checked after a memory read was issued, or while a stalled check waits
    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |->
            ($past(state_reg) == S_READ || $past(state_reg) == S_CHECK))
        else $error("compare state entered without a memory read");

endmodule

### hdl/scoo_tr_dpath.sv
// ============================================================================
// scoo_tr_dpath
// Datapath: entry memory, fill count, overflow flag, scan counters,
// one-entry hold register and the output register.
// ============================================================================
module scoo_tr_dpath
    import scoo_tr_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [NCOL_W-1:0]        num_cols,
    input  logic [ROW_W-1:0]         row_index,
    input  logic [COL_W-1:0]         col_index,
    input  logic signed [VAL_W-1:0]  entry_value,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]         out_col,
    output logic signed [VAL_W-1:0]  out_value,
    output logic [CNT_W-1:0]         entry_count,
    output logic                     overflow,
    output logic                     last_result
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ENTRIES);

    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              ovf_reg,    ovf_next;
    logic [AW-1:0]     j_reg,      j_next;
    logic [NCOL_W-1:0] c_reg,      c_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [COL_W-1:0]  hold_srccol_reg;
    logic [ROW_W-1:0]  hold_srcrow_reg;
    logic [VAL_W-1:0]  hold_val_reg;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [VAL_W-1:0]  out_val_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_ovf_reg;
    logic              out_last_reg;

    logic              full;
    logic [NCOL_W-1:0] limit;
    logic              last_j;
    logic              last_c;
    logic              out_free;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  rd_col;
    logic [VAL_W-1:0]  rd_val;

    // effective column count
    assign limit = (int'(num_cols) > MAX_DIM) ? NCOL_W'(MAX_DIM) : num_cols;

    assign full     = (count_reg == CAP);
    assign out_free = !out_valid_reg || !out_stall;

    // entry memory: {row, col, value}
    assign wr_data = {row_index, col_index, entry_value};

    scoo_tr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.load && !full),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (j_reg),
        .rd_data (rd_data)
    );

    assign rd_row = rd_data[ENTRY_W-1 -: ROW_W];
    assign rd_col = rd_data[VAL_W +: COL_W];
    assign rd_val = rd_data[VAL_W-1:0];

    // scan position checks
    assign last_j = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign last_c = ((c_reg + NCOL_W'(1)) == limit);

    // status to controller
    always_comb
    begin
        sts.limit_zero = (limit == '0);
        sts.match      = (NCOL_W'(rd_col) == c_reg);
        sts.scan_done  = last_j && last_c;
        sts.hold_valid = hold_valid_reg;
        sts.out_free   = out_free;
    end

    // next values of the control registers
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end

        j_next = j_reg;
        c_next = c_reg;
        if (cmd.scan_init)
        begin
            j_next = '0;
            c_next = '0;
        end
        else if (cmd.step)
        begin
            if (last_j)
            begin
                j_next = '0;
                c_next = c_reg + NCOL_W'(1);
            end
            else
            begin
                j_next = j_reg + AW'(1);
            end
        end

        hold_valid_next = hold_valid_reg;
        if (cmd.take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd.flush)
        begin
            hold_valid_next = 1'b0;
        end

        if (cmd.push || cmd.flush)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            j_reg          <= '0;
            c_reg          <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            j_reg          <= j_next;
            c_reg          <= c_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold register: one matching entry waits until the next one is known
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            hold_srccol_reg <= rd_col;
            hold_srcrow_reg <= rd_row;
            hold_val_reg    <= rd_val;
        end
    end

    // output register, row and column swapped
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.flush)
        begin
            out_row_reg  <= hold_srccol_reg;
            out_col_reg  <= hold_srcrow_reg;
            out_val_reg  <= hold_val_reg;
            out_cnt_reg  <= count_reg;
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_value   = out_val_reg;
    assign entry_count = out_cnt_reg;
    assign overflow    = out_ovf_reg;
    assign last_result = out_last_reg;

    // the output register is never overwritten while a request waits
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.flush) |-> out_free)
        else $error("output register overwritten while stalled");

    // fill count stays within the store
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("fill count beyond store capacity");

    // end of matrix leaves count and flag clear
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0 && !ovf_reg))
        else $error("count or overflow flag not cleared after matrix");

endmodule

### hdl/sparse_coo_transpose_core.sv
// ============================================================================
// sparse_coo_transpose_core
// Sparse matrix transpose in coordinate form, with register port.
// ============================================================================
// Entries (row, column, value) are taken one per cycle into an entry memory
// of MAX_ENTRIES words; entries beyond that are dropped and flagged. The
// request marked last_entry starts the transpose: the block stalls its input
// and, for each column below num_cols (limited to 256), reads every stored
// entry in load order and emits those of that column with row and column
// swapped. Each probe of one stored entry for one column sets the read
// address, then compares the registered read data; a closing step emits the
// held entry. The emit phase is longer when the output is stalled. One
// emitted request waits in a hold register so that the final one can carry
// last_result. No memory clearing pass is needed after reset. num_cols is
// the register at byte address 0, reset 256.
// ============================================================================
module sparse_coo_transpose_core
    import scoo_tr_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    // entry input
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ROW_W-1:0]         row_index,
    input  logic [COL_W-1:0]         col_index,
    input  logic signed [VAL_W-1:0]  entry_value,
    input  logic                     last_entry,
    // transposed output
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]         out_col,
    output logic signed [VAL_W-1:0]  out_value,
    output logic [CNT_W-1:0]         entry_count,
    output logic                     overflow,
    output logic                     last_result
);

    logic [NCOL_W-1:0] num_cols_reg;
    logic [NCOL_W-1:0] num_cols_next;
    logic              reg_sel;
    cmd_t              cmd;
    sts_t              sts;

    // register decode
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_NUM_COLS);

    always_comb
    begin
        num_cols_next = num_cols_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            num_cols_next = pwdata[NCOL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NUM_COLS_RESET;
        end
        else
        begin
            num_cols_reg <= num_cols_next;
        end
    end

    // register read back
    assign prdata = reg_sel ? DATA_W'(num_cols_reg) : '0;

    // controller
    scoo_tr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_entry (last_entry),
        .in_stall   (in_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath
    scoo_tr_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .num_cols    (num_cols_reg),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .entry_count (entry_count),
        .overflow    (overflow),
        .last_result (last_result)
    );

endmodule

### tb/tb.sv
// ============================================================================
// tb
// Self-checking bench for sparse_coo_transpose_core.
// ============================================================================
// Entry requests go in through the valid/stall input channel and transposed
// entries come back on the output channel. Each accepted request runs through
// a bench-side transpose predictor. Every emitted entry is compared field by
// field with the oldest predicted entry. num_cols is written over the APB port
// between phases and read back. A short directed table covers the field
// extremes, stable ordering inside a column, columns out of range and empty
// emits. Random matrices follow: store overflow, a store filled exactly, and
// random gaps and stalls on both channels.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scoo_tr_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int LONG_HOLD = 500;

    // one transposed entry as seen on the output
    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [VAL_W-1:0] out_value;
        logic [CNT_W-1:0] entry_count;
        logic             overflow;
        logic             last_result;
    } tr_entry_t;

    // directed request, with an optional typed-in result
    typedef struct packed {
        int               set_cols;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] val;
        logic             last;
        bit               typed;
        tr_entry_t        result;
    } directed_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [PADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [ROW_W-1:0]        row_index = '0;
    logic [COL_W-1:0]        col_index = '0;
    logic signed [VAL_W-1:0] entry_value = '0;
    logic                    last_entry = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    overflow;
    logic                    last_result;

    // predictor state
    logic [ROW_W-1:0] store_row [CAPACITY];
    logic [COL_W-1:0] store_col [CAPACITY];
    logic [VAL_W-1:0] store_val [CAPACITY];
    int               stored_cnt = 0;
    logic             drop_flag = 1'b0;
    logic [8:0]       num_cols_cfg = NUM_COLS_RESET;
    int               idle_tail = 20;

    tr_entry_t predicted [$];
    tr_entry_t transposed_q [$];

    int error_count = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int matrices_sent = 0;
    int overflow_matrices = 0;
    int config_writes = 0;
    int drain_pauses = 0;
    int burst_left = 0;

    directed_row_t directed_steps [14] = '{
        '{0,   8'd255, 8'd0,   32'h7fff_ffff, 1'b1, 1'b1,
          '{8'd0, 8'd255, 32'h7fff_ffff, 7'd1, 1'b0, 1'b1}},
        '{0,   8'd0,   8'd255, 32'h8000_0000, 1'b1, 1'b1,
          '{8'd255, 8'd0, 32'h8000_0000, 7'd1, 1'b0, 1'b1}},
        '{0,   8'd3,   8'd7,   32'hffff_ffff, 1'b0, 1'b0, '0},
        '{0,   8'd4,   8'd2,   32'd5,         1'b0, 1'b0, '0},
        '{0,   8'd9,   8'd7,   32'd100,       1'b0, 1'b0, '0},
        '{0,   8'd1,   8'd2,   32'hffff_fffb, 1'b1, 1'b0, '0},
        '{0,   8'd170, 8'd85,  32'haaaa_aaaa, 1'b0, 1'b0, '0},
        '{0,   8'd85,  8'd170, 32'h5555_5555, 1'b1, 1'b0, '0},
        '{1,   8'd5,   8'd1,   32'd42,        1'b1, 1'b0, '0},
        '{0,   8'd6,   8'd0,   32'd7,         1'b0, 1'b0, '0},
        '{0,   8'd8,   8'd200, 32'd9,         1'b1, 1'b1,
          '{8'd0, 8'd6, 32'd7, 7'd2, 1'b0, 1'b1}},
        '{0,   8'd0,   8'd0,   32'd0,         1'b1, 1'b1,
          '{8'd0, 8'd0, 32'd0, 7'd1, 1'b0, 1'b1}},
        '{255, 8'd1,   8'd255, 32'd3,         1'b1, 1'b0, '0},
        '{0,   8'd2,   8'd254, 32'd4,         1'b1, 1'b1,
          '{8'd254, 8'd2, 32'd4, 7'd1, 1'b0, 1'b1}}
    };

    sparse_coo_transpose_core #(
        .MAX_ENTRIES (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .last_entry  (last_entry),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .entry_count (entry_count),
        .overflow    (overflow),
        .last_result (last_result)
    );

    // 12 ns clock
    always #6ns clk = ~clk;

    // store one entry; on the marked one build the transposed list
    function automatic void predict_transpose(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                              logic [VAL_W-1:0] v, logic l);
        int        limit;
        tr_entry_t res;
        predicted.delete();
        if (stored_cnt < CAPACITY)
        begin
            store_row[stored_cnt] = r;
            store_col[stored_cnt] = c;
            store_val[stored_cnt] = v;
            stored_cnt++;
        end
        else
            drop_flag = 1'b1;
        if (!l)
            return;
        limit = (int'(num_cols_cfg) > MAX_DIM) ? MAX_DIM : int'(num_cols_cfg);
        for (int col_i = 0; col_i < limit; col_i++)
        begin
            for (int j = 0; j < stored_cnt; j++)
            begin
                if (int'(store_col[j]) == col_i && predicted.size() < CAPACITY)
                begin
                    res.out_row     = store_col[j];
                    res.out_col     = store_row[j];
                    res.out_value   = store_val[j];
                    res.entry_count = CNT_W'(stored_cnt);
                    res.overflow    = drop_flag;
                    res.last_result = 1'b0;
                    predicted.push_back(res);
                end
            end
        end
        if (predicted.size() > 0)
            predicted[predicted.size() - 1].last_result = 1'b1;
        // an empty emit still scans every column over every stored entry
        idle_tail = (predicted.size() == 0) ? 2 * limit * stored_cnt + 20 : 20;
        if (drop_flag)
            overflow_matrices++;
        matrices_sent++;
        stored_cnt = 0;
        drop_flag  = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // offer one request, wait for it to be taken, then predict
    task automatic send_request(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                input logic [VAL_W-1:0] v, input logic l,
                                input bit typed, input tr_entry_t typed_res);
        int gap;
        int pick;
        bit took;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                burst_left = $urandom_range(20, 60);
            else if (pick < 7)
                gap = $urandom_range(15, 50);
            else if (pick < 30)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_index   <= r;
        col_index   <= c;
        entry_value <= v;
        last_entry  <= l;
        in_valid    <= 1'b1;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        requests_sent++;
        predict_transpose(r, c, v, l);
        if (typed)
            transposed_q.push_back(typed_res);
        else
            foreach (predicted[i])
                transposed_q.push_back(predicted[i]);
    endtask

    // one random matrix; wild scatters columns over the whole range
    task automatic send_matrix(input int len, input bit wild);
        logic [COL_W-1:0] c;
        logic [VAL_W-1:0] v;
        int               top;
        top = (num_cols_cfg >= 9'd256) ? 255 : int'(num_cols_cfg) - 1;
        for (int k = 0; k < len; k++)
        begin
            if (wild || $urandom_range(0, 99) < 15)
                c = COL_W'($urandom_range(0, 255));
            else
                c = COL_W'($urandom_range(0, top));
            case ($urandom_range(0, 19))
                0:       v = 32'h7fff_ffff;
                1:       v = 32'h8000_0000;
                2:       v = 32'h0000_0000;
                3:       v = 32'hffff_ffff;
                default: v = $urandom;
            endcase
            send_request(ROW_W'($urandom_range(0, 255)), c, v, k == len - 1, 1'b0, '0);
        end
    endtask

    // wait until every predicted entry came out and the scan has settled
    task automatic wait_drained();
        do
            @(posedge clk);
        while (transposed_q.size() != 0);
        repeat (idle_tail) @(posedge clk);
    endtask

    // write num_cols, then read it back
    task automatic write_num_cols(input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NUM_COLS, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        num_cols_cfg = 9'(value);
        config_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        check_field("num_cols readback", DATA_W'(value), prdata);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // main stimulus
    initial
    begin : stimulus
        int phase_cols [6];
        int ncols;
        int phase_start;
        int pick;
        int len;
        phase_cols = '{8, 256, 1, 255, 37, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].set_cols != 0)
            begin
                in_valid <= 1'b0;
                wait_drained();
                write_num_cols(directed_steps[i].set_cols);
            end
            send_request(directed_steps[i].row, directed_steps[i].col, directed_steps[i].val,
                         directed_steps[i].last, directed_steps[i].typed,
                         directed_steps[i].result);
        end

        // random phases, one num_cols setting each
        foreach (phase_cols[p])
        begin
            ncols = (phase_cols[p] == 0) ? $urandom_range(1, 256) : phase_cols[p];
            in_valid <= 1'b0;
            wait_drained();
            write_num_cols(ncols);
            phase_start = requests_sent;
            if (p == 0)
            begin
                // overflow on the marked request, then a store filled exactly
                send_matrix(65, 1'b0);
                send_matrix(64, 1'b0);
            end
            while (requests_sent - phase_start < 45)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    len = $urandom_range(1, 10);
                else if (pick < 95)
                    len = $urandom_range(11, 40);
                else
                    len = $urandom_range(60, 70);
                send_matrix(len, $urandom_range(0, 99) < 8);
                // sender holds off until the output has drained
                if (matrices_sent % 7 == 3)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                    drain_pauses++;
                end
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        if (transposed_q.size() != 0)
        begin
            $error("%0d transposed entries never came out", transposed_q.size());
            error_count++;
        end
        $display("covered %0d requests in %0d matrices, %0d transposed entries checked",
                 requests_sent, matrices_sent, results_checked);
        $display("%0d num_cols writes, %0d matrices overflowed, %0d drain pauses",
                 config_writes, overflow_matrices, drain_pauses);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // output stall: short and long holds, quiet stretches, one long hold
    initial
    begin : receiver
        int hold_left;
        int quiet_left;
        int pick;
        bit long_hold_done;
        hold_left      = 0;
        quiet_left     = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && results_checked >= 40)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left == 0 && quiet_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    quiet_left = $urandom_range(30, 80);
                else if (pick < 7)
                    hold_left = $urandom_range(15, 50);
                else if (pick < 30)
                    hold_left = $urandom_range(1, 3);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (quiet_left > 0)
                    quiet_left--;
            end
        end
    end

    // compare each accepted output request with the oldest prediction
    always @(negedge clk)
    begin : result_check
        tr_entry_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (transposed_q.size() == 0)
            begin
                $error("unexpected output: row %0d col %0d value %0h",
                       out_row, out_col, out_value);
                error_count++;
            end
            else
            begin
                exp_res = transposed_q.pop_front();
                check_field("out_row", 32'(exp_res.out_row), 32'(out_row));
                check_field("out_col", 32'(exp_res.out_col), 32'(out_col));
                check_field("out_value", exp_res.out_value, out_value);
                check_field("entry_count", 32'(exp_res.entry_count), 32'(entry_count));
                check_field("overflow", 32'(exp_res.overflow), 32'(overflow));
                check_field("last_result", 32'(exp_res.last_result), 32'(last_result));
                results_checked++;
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        #100ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### sparse_coo_transpose_core.f
hdl/scoo_tr_pkg.sv
hdl/scoo_tr_ram.sv
hdl/scoo_tr_ctrl.sv
hdl/scoo_tr_dpath.sv
hdl/sparse_coo_transpose_core.sv
tb/tb.sv
